// File: hw/rtl/trs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Shared widths, types and codes for the TRS matrix composer.
// ----------------------------------------------------------------------------
package trs_pkg;

   // Q16.16 word and Q.16 rotation entry widths
   localparam int FIX_W = 32;
   localparam int QUAT_W = 16;
   localparam int ROT_W = 22;

   // rows sent for every request (three per matrix, two matrices)
   localparam int ROWS_PER_REQ = 6;
   localparam int GAP_W = $clog2(ROWS_PER_REQ);

   // last row index of a matrix
   localparam logic [1:0] ROW_LAST = 2'd2;

   typedef logic [FIX_W-1:0] fix_type;
   typedef logic [QUAT_W-1:0] quat_type;
   typedef logic [ROT_W-1:0] rot_type;

   typedef enum logic {
      KIND_AXIS = 1'b0,
      KIND_UNIFORM = 1'b1
   } kind_type;

   // one request as taken from the ports
   typedef struct packed {
      fix_type [2:0] pos;
      fix_type [2:0] scl;
      quat_type qw;
      quat_type qx;
      quat_type qy;
      quat_type qz;
   } req_type;

   // rotation in row-major order plus what the row stage needs
   typedef struct packed {
      rot_type [8:0] rot;
      fix_type [2:0] pos;
      fix_type [2:0] scl;
      fix_type smax;
   } rows_type;

endpackage

// File: hw/rtl/trs_rot_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_rot_unit
// Two-stage quaternion to rotation matrix unit, also picks the largest scale.
// ----------------------------------------------------------------------------
module trs_rot_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  trs_pkg::req_type  in_req,
   output logic              out_valid,
   output trs_pkg::rows_type out_rows
);

   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
   localparam logic signed [35:0] HALF_Q12 = 36'sd2048;

   // round half up to Q.16 with a floor shift
   function automatic trs_pkg::rot_type rnd(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = v + HALF_Q12;
      t = t >>> 12;
      return t[trs_pkg::ROT_W-1:0];
   endfunction

   function automatic logic signed [35:0] ext(input logic signed [31:0] v);
      return 36'(v);
   endfunction

   // stage 1: quaternion products and first scale compare
   logic               s1_vld_ff;
   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff;
   logic signed [31:0] p_yz_ff, p_xw_ff, p_yw_ff, p_zw_ff;
   logic signed [31:0] p_xx_in, p_yy_in, p_zz_in, p_xy_in, p_xz_in;
   logic signed [31:0] p_yz_in, p_xw_in, p_yw_in, p_zw_in;
   trs_pkg::fix_type   s1_pos_ff [3];
   trs_pkg::fix_type   s1_scl_ff [3];
   trs_pkg::fix_type   s1_max01_ff;
   trs_pkg::fix_type   s1_max01_in;

   always_comb begin
      p_xx_in = $signed(in_req.qx) * $signed(in_req.qx);
      p_yy_in = $signed(in_req.qy) * $signed(in_req.qy);
      p_zz_in = $signed(in_req.qz) * $signed(in_req.qz);
      p_xy_in = $signed(in_req.qx) * $signed(in_req.qy);
      p_xz_in = $signed(in_req.qx) * $signed(in_req.qz);
      p_yz_in = $signed(in_req.qy) * $signed(in_req.qz);
      p_xw_in = $signed(in_req.qx) * $signed(in_req.qw);
      p_yw_in = $signed(in_req.qy) * $signed(in_req.qw);
      p_zw_in = $signed(in_req.qz) * $signed(in_req.qw);
      if ($signed(in_req.scl[1]) > $signed(in_req.scl[0])) begin
         s1_max01_in = in_req.scl[1];
      end else begin
         s1_max01_in = in_req.scl[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
      end
      p_xx_ff <= p_xx_in;
      p_yy_ff <= p_yy_in;
      p_zz_ff <= p_zz_in;
      p_xy_ff <= p_xy_in;
      p_xz_ff <= p_xz_in;
      p_yz_ff <= p_yz_in;
      p_xw_ff <= p_xw_in;
      p_yw_ff <= p_yw_in;
      p_zw_ff <= p_zw_in;
      s1_max01_ff <= s1_max01_in;
      for (int i = 0; i < 3; i++) begin
         s1_pos_ff[i] <= in_req.pos[i];
         s1_scl_ff[i] <= in_req.scl[i];
      end
   end

   // stage 2: rotation entries in Q.16 and final scale compare
   logic              s2_vld_ff;
   trs_pkg::rows_type s2_rows_ff;
   trs_pkg::rows_type s2_rows_in;

   always_comb begin
      s2_rows_in.rot[0] = rnd(ONE_Q28 - ((ext(p_yy_ff) + ext(p_zz_ff)) <<< 1));
      s2_rows_in.rot[1] = rnd((ext(p_xy_ff) - ext(p_zw_ff)) <<< 1);
      s2_rows_in.rot[2] = rnd((ext(p_xz_ff) + ext(p_yw_ff)) <<< 1);
      s2_rows_in.rot[3] = rnd((ext(p_xy_ff) + ext(p_zw_ff)) <<< 1);
      s2_rows_in.rot[4] = rnd(ONE_Q28 - ((ext(p_xx_ff) + ext(p_zz_ff)) <<< 1));
      s2_rows_in.rot[5] = rnd((ext(p_yz_ff) - ext(p_xw_ff)) <<< 1);
      s2_rows_in.rot[6] = rnd((ext(p_xz_ff) - ext(p_yw_ff)) <<< 1);
      s2_rows_in.rot[7] = rnd((ext(p_yz_ff) + ext(p_xw_ff)) <<< 1);
      s2_rows_in.rot[8] = rnd(ONE_Q28 - ((ext(p_xx_ff) + ext(p_yy_ff)) <<< 1));
      for (int i = 0; i < 3; i++) begin
         s2_rows_in.pos[i] = s1_pos_ff[i];
         s2_rows_in.scl[i] = s1_scl_ff[i];
      end
      if ($signed(s1_scl_ff[2]) > $signed(s1_max01_ff)) begin
         s2_rows_in.smax = s1_scl_ff[2];
      end else begin
         s2_rows_in.smax = s1_max01_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_rows_ff <= s2_rows_in;
   end

   assign out_valid = s2_vld_ff;
   assign out_rows = s2_rows_ff;

endmodule

// File: hw/rtl/trs_matrix_compose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_matrix_compose
// Builds the T*R*S local matrix and its uniform max-scale variant, row by row.
// ----------------------------------------------------------------------------
// Usage:
//   A request (position, Q2.14 quaternion, per-axis scale) is taken on the
//   rising edge where start is high and busy is low. Each request produces six
//   rows on the rsp_ ports: rows 0..2 of the per-axis matrix, then rows 0..2
//   of the uniform max-scale matrix; rsp_last_row marks the sixth.
//   Each row is valid for one cycle while rsp_strobe is high; the receiver
//   must take it then, there is no back-pressure on the row channel.
//   The first row passes through the rotation unit, the row sequencer, the
//   multiply register and the output register; the rest follow on consecutive cycles.
//   Requests are paced by the single row multiplier stage that issues one
//   row per cycle. busy stays high after each accept while the gap counter
//   runs down; the next request enters while earlier rows are still going
//   out.
//   Reset (synchronous, active high) drops every request in flight and
//   clears busy and rsp_strobe.
// ----------------------------------------------------------------------------
module trs_matrix_compose (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [15:0] req_quat_w,
   input  logic [15:0] req_quat_x,
   input  logic [15:0] req_quat_y,
   input  logic [15:0] req_quat_z,
   input  logic [31:0] req_scale_x,
   input  logic [31:0] req_scale_y,
   input  logic [31:0] req_scale_z,
   output logic        rsp_strobe,
   output logic        rsp_matrix_kind,
   output logic [1:0]  rsp_row_index,
   output logic [31:0] rsp_col_0,
   output logic [31:0] rsp_col_1,
   output logic [31:0] rsp_col_2,
   output logic [31:0] rsp_translation,
   output logic        rsp_last_row
);

   localparam logic signed [53:0] HALF_Q16 = 54'sd32768;
   localparam logic signed [53:0] SAT_MAX = 54'sd2147483647;
   localparam logic signed [53:0] SAT_MIN = -54'sd2147483648;

   // round half up to Q16.16, then clamp to 32 bits
   function automatic trs_pkg::fix_type rnd_sat(input logic signed [53:0] p);
      logic signed [53:0] t;
      t = p + HALF_Q16;
      t = t >>> 16;
      if (t > SAT_MAX) begin
         return 32'h7fff_ffff;
      end else if (t < SAT_MIN) begin
         return 32'h8000_0000;
      end else begin
         return t[31:0];
      end
   endfunction

   // request spacing: one request per six row slots
   logic [trs_pkg::GAP_W-1:0] gap_ff;
   logic [trs_pkg::GAP_W-1:0] gap_in;
   logic                      accept;

   assign busy = (gap_ff != '0);
   assign accept = start && !busy;

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = trs_pkg::GAP_W'(trs_pkg::ROWS_PER_REQ - 1);
      end else if (gap_ff != '0) begin
         gap_in = gap_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   // rotation front end
   trs_pkg::req_type  req;
   logic              rot_vld;
   trs_pkg::rows_type rot_rows;

   always_comb begin
      req.pos[0] = req_pos_x;
      req.pos[1] = req_pos_y;
      req.pos[2] = req_pos_z;
      req.scl[0] = req_scale_x;
      req.scl[1] = req_scale_y;
      req.scl[2] = req_scale_z;
      req.qw = req_quat_w;
      req.qx = req_quat_x;
      req.qy = req_quat_y;
      req.qz = req_quat_z;
   end

   trs_rot_unit u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req),
      .out_valid (rot_vld),
      .out_rows  (rot_rows)
   );

   // row sequencer: holds one request and walks its six rows
   trs_pkg::rows_type  hold_ff;
   trs_pkg::rows_type  hold_in;
   logic               act_ff, act_in;
   logic [1:0]         row_ff, row_in;
   trs_pkg::kind_type  kind_ff, kind_in;

   always_comb begin
      hold_in = hold_ff;
      act_in = act_ff;
      row_in = row_ff;
      kind_in = kind_ff;
      if (rot_vld) begin
         hold_in = rot_rows;
         act_in = 1'b1;
         row_in = 2'd0;
         kind_in = trs_pkg::KIND_AXIS;
      end else if (act_ff) begin
         if (row_ff == trs_pkg::ROW_LAST) begin
            row_in = 2'd0;
            if (kind_ff == trs_pkg::KIND_UNIFORM) begin
               act_in = 1'b0;
            end else begin
               kind_in = trs_pkg::KIND_UNIFORM;
            end
         end else begin
            row_in = row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= 2'd0;
         kind_ff <= trs_pkg::KIND_AXIS;
      end else begin
         act_ff <= act_in;
         row_ff <= row_in;
         kind_ff <= kind_in;
      end
      hold_ff <= hold_in;
   end

   // row select and scale multiply
   trs_pkg::rot_type   sel_rot [3];
   trs_pkg::fix_type   sel_scl [3];
   trs_pkg::fix_type   sel_pos;
   logic signed [53:0] mul_prod_in [3];

   always_comb begin
      case (row_ff)
         2'd0: begin
            sel_pos = hold_ff.pos[0];
            for (int j = 0; j < 3; j++) sel_rot[j] = hold_ff.rot[j];
         end
         2'd1: begin
            sel_pos = hold_ff.pos[1];
            for (int j = 0; j < 3; j++) sel_rot[j] = hold_ff.rot[3 + j];
         end
         2'd2: begin
            sel_pos = hold_ff.pos[2];
            for (int j = 0; j < 3; j++) sel_rot[j] = hold_ff.rot[6 + j];
         end
         default: begin
            sel_pos = hold_ff.pos[0];
            for (int j = 0; j < 3; j++) sel_rot[j] = hold_ff.rot[j];
         end
      endcase
      for (int j = 0; j < 3; j++) begin
         sel_scl[j] = (kind_ff == trs_pkg::KIND_UNIFORM) ? hold_ff.smax : hold_ff.scl[j];
         mul_prod_in[j] = $signed(sel_rot[j]) * $signed(sel_scl[j]);
      end
   end

   logic               mul_vld_ff;
   logic signed [53:0] mul_prod_ff [3];
   trs_pkg::fix_type   mul_pos_ff;
   trs_pkg::kind_type  mul_kind_ff;
   logic [1:0]         mul_row_ff;
   logic               mul_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= act_ff;
      end
      for (int j = 0; j < 3; j++) mul_prod_ff[j] <= mul_prod_in[j];
      mul_pos_ff <= sel_pos;
      mul_kind_ff <= kind_ff;
      mul_row_ff <= row_ff;
      mul_last_ff <= (kind_ff == trs_pkg::KIND_UNIFORM) && (row_ff == trs_pkg::ROW_LAST);
   end

   // output register: round and saturate
   logic             out_vld_ff;
   trs_pkg::fix_type out_col_ff [3];
   trs_pkg::fix_type out_pos_ff;
   logic             out_kind_ff;
   logic [1:0]       out_row_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= mul_vld_ff;
      end
      for (int j = 0; j < 3; j++) out_col_ff[j] <= rnd_sat(mul_prod_ff[j]);
      out_pos_ff <= mul_pos_ff;
      out_kind_ff <= mul_kind_ff;
      out_row_ff <= mul_row_ff;
      out_last_ff <= mul_last_ff;
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_matrix_kind = out_kind_ff;
   assign rsp_row_index = out_row_ff;
   assign rsp_col_0 = out_col_ff[0];
   assign rsp_col_1 = out_col_ff[1];
   assign rsp_col_2 = out_col_ff[2];
   assign rsp_translation = out_pos_ff;
   assign rsp_last_row = out_last_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rot_vld |-> (!act_ff || (kind_ff == trs_pkg::KIND_UNIFORM
                               && row_ff == trs_pkg::ROW_LAST)))
      else $error("new request reached sequencer mid-walk");

   a_rows_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_row) |=> rsp_strobe)
      else $error("row burst broken before last row");

   a_last_row_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_row) |-> (rsp_matrix_kind && rsp_row_index == trs_pkg::ROW_LAST))
      else $error("last row flag on wrong row");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      act_ff |-> (row_ff != 2'd3))
      else $error("row counter out of range");

endmodule

// File: verif/trs_matrix_compose_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_matrix_compose_tb
// Self-checking bench for the TRS matrix composer.
// ----------------------------------------------------------------------------
// A queue of staged requests feeds a falling-edge driver with random idle
// gaps, back-to-back stretches and drain pauses. A rising-edge monitor
// predicts the six Q16.16 rows of every accepted request. It then compares
// each strobed row, field by field, with the oldest predicted row. Requests
// start with directed corners: identity, quarter and half turns,
// non-unit quaternions, saturating and negative or tied scales. A random
// mix of unit, raw and axis-aligned quaternions follows.
// ----------------------------------------------------------------------------
module trs_matrix_compose_tb;

   localparam longint ONE_Q28 = 64'sd268435456;
   localparam longint FIX_MAX = 64'sd2147483647;
   localparam longint FIX_MIN = -64'sd2147483648;
   localparam trs_pkg::fix_type FIX_ONE = 32'h0001_0000;
   localparam trs_pkg::fix_type FIX_TOP = 32'h7FFF_FFFF;
   localparam trs_pkg::fix_type FIX_BOT = 32'h8000_0000;
   localparam trs_pkg::quat_type Q_ONE = 16'h4000;
   localparam trs_pkg::quat_type Q_HALF_SQRT2 = 16'd11585;
   localparam trs_pkg::quat_type Q_TOP = 16'h7FFF;
   localparam trs_pkg::quat_type Q_BOT = 16'h8000;
   localparam int NUM_RANDOM = 350;

   // request plus how the driver should pace it
   typedef struct {
      trs_pkg::req_type body;
      int gap_after;
      bit drain_first;
   } staged_req_type;

   // one matrix row as it leaves the block
   typedef struct packed {
      trs_pkg::kind_type kind;
      logic [1:0] row;
      trs_pkg::fix_type c0;
      trs_pkg::fix_type c1;
      trs_pkg::fix_type c2;
      trs_pkg::fix_type tr;
      logic last;
   } trs_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   trs_pkg::fix_type req_pos_x = '0;
   trs_pkg::fix_type req_pos_y = '0;
   trs_pkg::fix_type req_pos_z = '0;
   trs_pkg::quat_type req_quat_w = '0;
   trs_pkg::quat_type req_quat_x = '0;
   trs_pkg::quat_type req_quat_y = '0;
   trs_pkg::quat_type req_quat_z = '0;
   trs_pkg::fix_type req_scale_x = '0;
   trs_pkg::fix_type req_scale_y = '0;
   trs_pkg::fix_type req_scale_z = '0;
   logic rsp_strobe;
   logic rsp_matrix_kind;
   logic [1:0] rsp_row_index;
   trs_pkg::fix_type rsp_col_0;
   trs_pkg::fix_type rsp_col_1;
   trs_pkg::fix_type rsp_col_2;
   trs_pkg::fix_type rsp_translation;
   logic rsp_last_row;

   staged_req_type requests_pending[$];
   trs_row_type rows_due[$];
   logic req_taken = 1'b0;
   int idle_left = 0;
   int requests_taken = 0;
   int rows_checked = 0;
   int row_errors = 0;
   int orphan_rows = 0;
   int sat_entries = 0;
   int num_directed = 0;

   trs_matrix_compose dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_quat_w(req_quat_w),
      .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z),
      .req_scale_x(req_scale_x),
      .req_scale_y(req_scale_y),
      .req_scale_z(req_scale_z),
      .rsp_strobe(rsp_strobe),
      .rsp_matrix_kind(rsp_matrix_kind),
      .rsp_row_index(rsp_row_index),
      .rsp_col_0(rsp_col_0),
      .rsp_col_1(rsp_col_1),
      .rsp_col_2(rsp_col_2),
      .rsp_translation(rsp_translation),
      .rsp_last_row(rsp_last_row)
   );

   always #5 clock = ~clock;

   // add half an LSB, then floor shift
   function automatic longint round_floor_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   // rows of T*R*S and T*R*(m,m,m) for one request
   task automatic predict_trs_rows(input trs_pkg::req_type rq);
      longint qw, qx, qy, qz, smax, s, full;
      longint rot [0:8];
      longint scl [0:2];
      trs_pkg::fix_type cols [0:2];
      trs_row_type row;
      qw = longint'($signed(rq.qw));
      qx = longint'($signed(rq.qx));
      qy = longint'($signed(rq.qy));
      qz = longint'($signed(rq.qz));
      // rotation in Q.28, row-major
      rot[0] = ONE_Q28 - 2 * (qy * qy + qz * qz);
      rot[1] = 2 * (qx * qy - qz * qw);
      rot[2] = 2 * (qx * qz + qy * qw);
      rot[3] = 2 * (qx * qy + qz * qw);
      rot[4] = ONE_Q28 - 2 * (qx * qx + qz * qz);
      rot[5] = 2 * (qy * qz - qx * qw);
      rot[6] = 2 * (qx * qz - qy * qw);
      rot[7] = 2 * (qy * qz + qx * qw);
      rot[8] = ONE_Q28 - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 9; i++)
         rot[i] = round_floor_shift(rot[i], 12);
      for (int j = 0; j < 3; j++)
         scl[j] = longint'($signed(rq.scl[j]));
      // largest scale by signed compare
      smax = scl[0];
      if (scl[1] > smax) smax = scl[1];
      if (scl[2] > smax) smax = scl[2];
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s = (k == 0) ? scl[j] : smax;
               full = round_floor_shift(rot[3 * i + j] * s, 16);
               if (full > FIX_MAX) begin
                  cols[j] = FIX_TOP;
                  sat_entries++;
               end else if (full < FIX_MIN) begin
                  cols[j] = FIX_BOT;
                  sat_entries++;
               end else begin
                  cols[j] = full[31:0];
               end
            end
            row.kind = (k == 0) ? trs_pkg::KIND_AXIS : trs_pkg::KIND_UNIFORM;
            row.row = 2'(i);
            row.c0 = cols[0];
            row.c1 = cols[1];
            row.c2 = cols[2];
            row.tr = rq.pos[i];
            row.last = (k == 1 && 2'(i) == trs_pkg::ROW_LAST);
            rows_due.push_back(row);
         end
      end
   endtask

   function automatic staged_req_type make_req(
      input trs_pkg::fix_type px, input trs_pkg::fix_type py,
      input trs_pkg::fix_type pz,
      input trs_pkg::quat_type qw, input trs_pkg::quat_type qx,
      input trs_pkg::quat_type qy, input trs_pkg::quat_type qz,
      input trs_pkg::fix_type sx, input trs_pkg::fix_type sy,
      input trs_pkg::fix_type sz);
      staged_req_type r;
      r.body.pos[0] = px;
      r.body.pos[1] = py;
      r.body.pos[2] = pz;
      r.body.qw = qw;
      r.body.qx = qx;
      r.body.qy = qy;
      r.body.qz = qz;
      r.body.scl[0] = sx;
      r.body.scl[1] = sy;
      r.body.scl[2] = sz;
      r.gap_after = 0;
      r.drain_first = 1'b0;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // signed value spread evenly over +/- span
   function automatic trs_pkg::fix_type rand_span(input int span);
      return trs_pkg::fix_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // position: mostly any 32-bit word, sometimes a moderate span
   function automatic trs_pkg::fix_type rand_pos();
      if ($urandom_range(0, 99) < 70) return trs_pkg::fix_type'($urandom);
      return rand_span(32'h0100_0000);
   endfunction

   function automatic trs_pkg::quat_type axis_part();
      case ($urandom_range(0, 6))
         0: return Q_ONE;
         1: return -Q_ONE;
         2: return Q_HALF_SQRT2;
         3: return -Q_HALF_SQRT2;
         4: return Q_TOP;
         5: return Q_BOT;
         default: return '0;
      endcase
   endfunction

   // random rotation scaled to unit norm in Q2.14
   task automatic unit_quat(output trs_pkg::quat_type w, output trs_pkg::quat_type x,
                            output trs_pkg::quat_type y, output trs_pkg::quat_type z);
      real a [0:3];
      real nrm;
      nrm = 0.0;
      for (int i = 0; i < 4; i++) begin
         a[i] = real'(int'($urandom_range(0, 65535)) - 32768);
         nrm = nrm + a[i] * a[i];
      end
      nrm = $sqrt(nrm);
      if (nrm < 1.0) begin
         a[0] = 1.0;
         nrm = 1.0;
      end
      w = trs_pkg::quat_type'($rtoi(a[0] / nrm * 16384.0));
      x = trs_pkg::quat_type'($rtoi(a[1] / nrm * 16384.0));
      y = trs_pkg::quat_type'($rtoi(a[2] / nrm * 16384.0));
      z = trs_pkg::quat_type'($rtoi(a[3] / nrm * 16384.0));
   endtask

   function automatic trs_pkg::fix_type rand_scale();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return rand_span(32'h0010_0000);
      if (r < 75) return trs_pkg::fix_type'($urandom);
      return rand_span(32'h0002_0000);
   endfunction

   // request driver: changes inputs on the falling edge
   always @(negedge clock) begin : drive_req
      staged_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold the request until the block takes it
      end else if (idle_left != 0) begin
         start <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (requests_pending.size() == 0 ||
                   (requests_pending[0].drain_first && rows_due.size() != 0)) begin
         start <= 1'b0;
      end else begin
         nxt = requests_pending.pop_front();
         req_pos_x <= nxt.body.pos[0];
         req_pos_y <= nxt.body.pos[1];
         req_pos_z <= nxt.body.pos[2];
         req_quat_w <= nxt.body.qw;
         req_quat_x <= nxt.body.qx;
         req_quat_y <= nxt.body.qy;
         req_quat_z <= nxt.body.qz;
         req_scale_x <= nxt.body.scl[0];
         req_scale_y <= nxt.body.scl[1];
         req_scale_z <= nxt.body.scl[2];
         start <= 1'b1;
         idle_left <= nxt.gap_after;
      end
   end

   // monitor: check strobed rows, then predict rows of a newly taken request
   always @(posedge clock) begin : watch_rsp
      trs_row_type want, got;
      trs_pkg::req_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            got.kind = trs_pkg::kind_type'(rsp_matrix_kind);
            got.row = rsp_row_index;
            got.c0 = rsp_col_0;
            got.c1 = rsp_col_1;
            got.c2 = rsp_col_2;
            got.tr = rsp_translation;
            got.last = rsp_last_row;
            if (rows_due.size() == 0) begin
               orphan_rows++;
               if (row_errors + orphan_rows <= 10)
                  $display("%0t: row with no request pending: kind %0d row %0d", $realtime,
                           got.kind, got.row);
            end else begin
               want = rows_due.pop_front();
               rows_checked++;
               if (got.kind !== want.kind || got.row !== want.row ||
                   got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
                   got.tr !== want.tr || got.last !== want.last) begin
                  row_errors++;
                  if (row_errors + orphan_rows <= 10) begin
                     $display("%0t: row mismatch (kind row col0 col1 col2 trans last)",
                              $realtime);
                     $display("   exp %0d %0d %h %h %h %h %0d", want.kind, want.row,
                              want.c0, want.c1, want.c2, want.tr, want.last);
                     $display("   got %0d %0d %h %h %h %h %0d", got.kind, got.row,
                              got.c0, got.c1, got.c2, got.tr, got.last);
                  end
               end
            end
         end
         if (start && !busy) begin
            seen.pos[0] = req_pos_x;
            seen.pos[1] = req_pos_y;
            seen.pos[2] = req_pos_z;
            seen.qw = req_quat_w;
            seen.qx = req_quat_x;
            seen.qy = req_quat_y;
            seen.qz = req_quat_z;
            seen.scl[0] = req_scale_x;
            seen.scl[1] = req_scale_y;
            seen.scl[2] = req_scale_z;
            predict_trs_rows(seen);
            requests_taken++;
         end
         req_taken <= start && !busy;
      end
   end

   // stimulus and end of run
   initial begin : main_seq
      staged_req_type r;
      trs_pkg::quat_type w, x, y, z;
      int qsel, ssel;
      // directed corners, back to back
      requests_pending.push_back(make_req('0, '0, '0, Q_ONE, '0, '0, '0,
                                          FIX_ONE, FIX_ONE, FIX_ONE));
      requests_pending.push_back(make_req(FIX_TOP, FIX_TOP, FIX_TOP, Q_ONE, '0, '0, '0,
                                          FIX_ONE, FIX_ONE, FIX_ONE));
      requests_pending.push_back(make_req(FIX_BOT, FIX_BOT, FIX_BOT, Q_ONE, '0, '0, '0,
                                          FIX_ONE, FIX_ONE, FIX_ONE));
      // quarter turns about each axis
      requests_pending.push_back(make_req(FIX_ONE, -FIX_ONE, 32'h0003_8000,
                                          Q_HALF_SQRT2, Q_HALF_SQRT2, '0, '0,
                                          FIX_ONE, 2 * FIX_ONE, 3 * FIX_ONE));
      requests_pending.push_back(make_req('0, '0, '0, Q_HALF_SQRT2, '0, Q_HALF_SQRT2, '0,
                                          -FIX_ONE, 2 * FIX_ONE, -3 * FIX_ONE));
      requests_pending.push_back(make_req('0, '0, '0, Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2,
                                          32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
      // a half turn about x, then a turn about y with negative scalar part
      requests_pending.push_back(make_req('0, '0, '0, '0, Q_ONE, '0, '0,
                                          FIX_ONE, FIX_ONE, 2 * FIX_ONE));
      requests_pending.push_back(make_req('0, '0, '0, -Q_HALF_SQRT2, '0, Q_HALF_SQRT2, '0,
                                          3 * FIX_ONE, FIX_ONE, 2 * FIX_ONE));
      // non-unit quaternions against extreme scales: saturation both ways
      requests_pending.push_back(make_req(32'h1234_5678, 32'h9ABC_DEF0, '0,
                                          Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                                          FIX_TOP, FIX_TOP, FIX_TOP));
      requests_pending.push_back(make_req('0, '0, '0, Q_BOT, Q_BOT, Q_BOT, Q_BOT,
                                          FIX_BOT, FIX_BOT, FIX_BOT));
      requests_pending.push_back(make_req('0, '0, '0, '0, '0, '0, '0,
                                          FIX_TOP, FIX_BOT, FIX_ONE));
      requests_pending.push_back(make_req('0, '0, '0, '0, Q_TOP, '0, '0,
                                          FIX_TOP, FIX_TOP, FIX_BOT));
      requests_pending.push_back(make_req('0, '0, '0, Q_BOT, '0, '0, '0,
                                          FIX_ONE, FIX_ONE, FIX_ONE));
      // tied largest scales, all negative, all zero
      requests_pending.push_back(make_req('0, '0, '0, Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2,
                                          2 * FIX_ONE, 2 * FIX_ONE, FIX_ONE));
      requests_pending.push_back(make_req('0, '0, '0, Q_ONE, '0, '0, '0,
                                          5 * FIX_ONE, 5 * FIX_ONE, 5 * FIX_ONE));
      r = make_req('0, '0, '0, '0, '0, Q_ONE, '0,
                   -FIX_ONE, -2 * FIX_ONE, -3 * FIX_ONE);
      r.drain_first = 1'b1;
      requests_pending.push_back(r);
      requests_pending.push_back(make_req(FIX_ONE, FIX_ONE, FIX_ONE,
                                          Q_HALF_SQRT2, Q_HALF_SQRT2, '0, '0, '0, '0, '0));
      // alternating bit patterns
      requests_pending.push_back(make_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
      requests_pending.push_back(make_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                          16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
      num_directed = requests_pending.size();

      // random requests
      for (int n = 0; n < NUM_RANDOM; n++) begin
         qsel = $urandom_range(0, 99);
         if (qsel < 50) begin
            unit_quat(w, x, y, z);
         end else if (qsel < 80) begin
            w = trs_pkg::quat_type'($urandom);
            x = trs_pkg::quat_type'($urandom);
            y = trs_pkg::quat_type'($urandom);
            z = trs_pkg::quat_type'($urandom);
         end else begin
            w = axis_part();
            x = axis_part();
            y = axis_part();
            z = axis_part();
         end
         r = make_req(rand_pos(), rand_pos(), rand_pos(),
                      w, x, y, z, rand_scale(), rand_scale(), rand_scale());
         // some with two or three equal scales
         ssel = $urandom_range(0, 99);
         if (ssel < 10)
            r.body.scl[$urandom_range(1, 2)] = r.body.scl[0];
         else if (ssel < 15)
            r.body.scl[2] = r.body.scl[1];
         else if (ssel < 20) begin
            r.body.scl[1] = r.body.scl[0];
            r.body.scl[2] = r.body.scl[0];
         end
         // stretches of back-to-back requests between idle spells
         r.gap_after = ((n / 40) % 3 == 1) ? 0 : pick_gap();
         r.drain_first = (n == 0) || ($urandom_range(0, 99) < 3);
         requests_pending.push_back(r);
      end

      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_pending.size() != 0 || start) @(posedge clock);
      while (rows_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Summary: %0d requests (%0d directed corners, rest random) gave %0d rows,",
               requests_taken, num_directed, rows_checked);
      $display("Summary: %0d saturated entries predicted, %0d bad rows, %0d rows unasked",
               sat_entries, row_errors, orphan_rows);
      if (row_errors == 0 && orphan_rows == 0 && rows_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("Timeout with %0d requests queued and %0d rows outstanding",
               requests_pending.size(), rows_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
